>>> hw/rtl/kwsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword substitution cipher package
// Shared widths, register indexes and types for the cipher block.
// ----------------------------------------------------------------------------
package kwsc_pkg;

   localparam int CharWidth      = 8;
   localparam int LetterWidth    = 5;
   localparam int AlphaSize      = 26;
   localparam int LettersPerReg  = 12;
   localparam int KeyRegs        = 4;
   localparam int KeyLenWidth    = 6;
   localparam int KeyRegWidth    = LettersPerReg * LetterWidth;
   localparam int MaxKeyLetters  = 48;
   localparam int LowerA         = 97;
   localparam int LowerZ         = 122;

   // register map of the configuration port
   localparam int CsrIdxWidth    = 3;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLength   = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLettersA = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLettersB = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLettersC = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrKeyLettersD = 3'd4;

   typedef logic [LetterWidth-1:0]                   letter_type;
   typedef logic [LettersPerReg-1:0][LetterWidth-1:0] key_word_type;
   typedef key_word_type [KeyRegs-1:0]              key_bank_type;

   // one write into the substitution table
   typedef struct packed {
      logic       en;
      letter_type pos;
      letter_type letter;
   } tbl_wr_type;

endpackage : kwsc_pkg
`default_nettype wire

>>> hw/rtl/kwsc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Plaintext channel
// Valid/ready channel carrying one plaintext byte per transaction.
// ----------------------------------------------------------------------------
interface kwsc_req_if;
   import kwsc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] plain_char;

   modport source (output valid, output plain_char, input ready);
   modport sink   (input valid, input plain_char, output ready);
endinterface : kwsc_req_if
`default_nettype wire

>>> hw/rtl/kwsc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ciphertext channel
// Valid/ready channel carrying one ciphertext byte per transaction.
// ----------------------------------------------------------------------------
interface kwsc_rsp_if;
   import kwsc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] cipher_char;

   modport source (output valid, output cipher_char, input ready);
   modport sink   (input valid, input cipher_char, output ready);
endinterface : kwsc_rsp_if
`default_nettype wire

>>> hw/rtl/kwsc_csr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kwsc_csr_if;
   import kwsc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] reg_index;
   logic [KeyRegWidth-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface : kwsc_csr_if
`default_nettype wire

>>> hw/rtl/keyword_substitution_cipher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit
// Encrypts a byte stream through a keyword-derived substitution alphabet.
// ----------------------------------------------------------------------------
// After reset and after every write to a register in the map, the unit
// rebuilds its 26-letter substitution table before it takes any plaintext:
// it starts, walks the keyword letters in use (key_length, capped at 48),
// turns over, and then walks the alphabet from z down to a for the remaining
// letters. A single placement unit decides every table slot, one letter per
// cycle. Keyword codes 26 to 31 and repeated letters take no slot. Once the
// table is built, in each plaintext transaction lowercase a to z is
// replaced by the table letter at its alphabet position, any other byte passes
// through unchanged. The result sits in an output register, so a new byte is
// taken while the previous result is handed over. Configuration writes are
// always accepted; a write to an index above 4 is dropped and leaves the
// table alone. Write configuration only while no result is outstanding.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit (
   input  wire        clock,
   input  wire        reset,
   kwsc_req_if.sink   req_chan,
   kwsc_rsp_if.source rsp_chan,
   kwsc_csr_if.sink   csr_chan
);
   import kwsc_pkg::*;

   logic [KeyLenWidth-1:0] key_length_ff;
   key_bank_type           key_bank_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]   cipher_ff;

   logic                   cfg_wr;
   logic                   req_take;
   logic                   table_ready;
   tbl_wr_type             tbl_wr;
   logic [CharWidth-1:0]   cipher_char;

   // accept every configuration transaction; only mapped indexes count
   assign csr_chan.ready = 1'b1;
   assign cfg_wr = csr_chan.valid && (csr_chan.reg_index <= CsrKeyLettersD);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         key_bank_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CsrKeyLength:   key_length_ff  <= csr_chan.wr_data[KeyLenWidth-1:0];
            CsrKeyLettersA: key_bank_ff[0] <= csr_chan.wr_data;
            CsrKeyLettersB: key_bank_ff[1] <= csr_chan.wr_data;
            CsrKeyLettersC: key_bank_ff[2] <= csr_chan.wr_data;
            CsrKeyLettersD: key_bank_ff[3] <= csr_chan.wr_data;
            default: begin
            end
         endcase
      end
   end

   // build the table from the held keyword
   kwsc_build_seq u_build (
      .clock       (clock),
      .reset       (reset),
      .cfg_wr      (cfg_wr),
      .key_length  (key_length_ff),
      .key_bank    (key_bank_ff),
      .tbl_wr      (tbl_wr),
      .table_ready (table_ready)
   );

   // look up the incoming byte
   kwsc_table u_table (
      .clock       (clock),
      .tbl_wr      (tbl_wr),
      .plain_char  (req_chan.plain_char),
      .cipher_char (cipher_char)
   );

   // take a byte when the table is built and the output register frees up
   assign req_chan.ready = table_ready && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until the sink takes it
   always_ff @(posedge clock) begin
      if (req_take) begin
         cipher_ff <= cipher_char;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cipher_char = cipher_ff;

   a_take_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_chan.valid)
      else $error("accepted byte produced no result");

   a_write_stops_input: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> !req_chan.ready)
      else $error("plaintext accepted before the table was rebuilt");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready)
      |=> (rsp_chan.valid && $stable(rsp_chan.cipher_char)))
      else $error("stalled result dropped or changed");

endmodule : keyword_substitution_cipher_unit
`default_nettype wire

>>> hw/rtl/kwsc_place_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Letter placement unit
// Decides whether a candidate letter takes the next table slot.
// ----------------------------------------------------------------------------
module kwsc_place_unit (
   input  wire kwsc_pkg::letter_type           cand,
   input  wire [kwsc_pkg::AlphaSize-1:0]       used,
   input  wire kwsc_pkg::letter_type           pos,
   output logic                                place,
   output logic [kwsc_pkg::AlphaSize-1:0]      used_next
);
   import kwsc_pkg::*;

   localparam int ExtWidth = 1 << LetterWidth;

   logic [ExtWidth-1:0] used_ext;
   logic [ExtWidth-1:0] mark;

   assign used_ext  = {{(ExtWidth-AlphaSize){1'b0}}, used};
   assign mark      = ExtWidth'(1) << cand;
   assign place     = (cand < LetterWidth'(AlphaSize)) && !used_ext[cand]
                      && (pos < LetterWidth'(AlphaSize));
   assign used_next = used | mark[AlphaSize-1:0];

endmodule : kwsc_place_unit
`default_nettype wire

>>> hw/rtl/kwsc_build_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Table build sequencer
// Walks the keyword, then the alphabet from z down, one letter a cycle.
// ----------------------------------------------------------------------------
module kwsc_build_seq (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  cfg_wr,
   input  wire [kwsc_pkg::KeyLenWidth-1:0]      key_length,
   input  wire kwsc_pkg::key_bank_type          key_bank,
   output kwsc_pkg::tbl_wr_type                 tbl_wr,
   output logic                                 table_ready
);
   import kwsc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEY  = 2'd1;
   localparam logic [1:0] ST_FILL = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic                   table_ready_ff, table_ready_in;
   logic [KeyLenWidth-1:0] key_idx_ff, key_idx_in;
   logic [1:0]             reg_sel_ff, reg_sel_in;
   logic [3:0]             slot_ff, slot_in;
   letter_type             fill_ff, fill_in;
   letter_type             pos_ff, pos_in;
   logic [AlphaSize-1:0]   used_ff, used_in;

   logic [KeyLenWidth-1:0] key_count;
   key_word_type           key_word;
   letter_type             cand;
   logic                   cand_active;
   logic                   place;
   logic [AlphaSize-1:0]   used_next;

   assign key_count = (key_length > KeyLenWidth'(MaxKeyLetters))
                      ? KeyLenWidth'(MaxKeyLetters) : key_length;
   assign key_word  = key_bank[reg_sel_ff];
   assign cand      = (state_ff == ST_KEY) ? key_word[slot_ff] : fill_ff;

   kwsc_place_unit u_place (
      .cand      (cand),
      .used      (used_ff),
      .pos       (pos_ff),
      .place     (place),
      .used_next (used_next)
   );

   always_comb begin
      state_in       = state_ff;
      table_ready_in = table_ready_ff;
      key_idx_in     = key_idx_ff;
      reg_sel_in     = reg_sel_ff;
      slot_in        = slot_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      used_in        = used_ff;
      cand_active    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!table_ready_ff) begin
               state_in   = ST_KEY;
               key_idx_in = '0;
               reg_sel_in = '0;
               slot_in    = '0;
               pos_in     = '0;
               used_in    = '0;
            end
         end
         ST_KEY: begin
            if (key_idx_ff == key_count) begin
               state_in = ST_FILL;
               fill_in  = LetterWidth'(AlphaSize - 1);
            end else begin
               cand_active = 1'b1;
               key_idx_in  = key_idx_ff + KeyLenWidth'(1);
               if (slot_ff == 4'(LettersPerReg - 1)) begin
                  slot_in    = '0;
                  reg_sel_in = reg_sel_ff + 2'd1;
               end else begin
                  slot_in = slot_ff + 4'd1;
               end
            end
         end
         ST_FILL: begin
            cand_active = 1'b1;
            if (fill_ff == '0) begin
               state_in       = ST_IDLE;
               table_ready_in = 1'b1;
            end else begin
               fill_in = fill_ff - LetterWidth'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cand_active && place) begin
         pos_in  = pos_ff + LetterWidth'(1);
         used_in = used_next;
      end
      // a register write abandons any build and forces a fresh one
      if (cfg_wr) begin
         state_in       = ST_IDLE;
         table_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         table_ready_ff <= 1'b0;
         pos_ff         <= '0;
         used_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         table_ready_ff <= table_ready_in;
         pos_ff         <= pos_in;
         used_ff        <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      key_idx_ff <= key_idx_in;
      reg_sel_ff <= reg_sel_in;
      slot_ff    <= slot_in;
      fill_ff    <= fill_in;
   end

   assign tbl_wr.en     = cand_active && place;
   assign tbl_wr.pos    = pos_ff;
   assign tbl_wr.letter = cand;
   assign table_ready   = table_ready_ff;

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      table_ready_ff |-> (state_ff == ST_IDLE))
      else $error("table marked ready while a build is running");

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ($countones(used_ff) == 32'(pos_ff)))
      else $error("placed letter mask disagrees with table position");

   a_full_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && fill_ff == '0 && !cfg_wr)
      |=> (table_ready_ff && pos_ff == LetterWidth'(AlphaSize)))
      else $error("build finished without filling every table entry");

endmodule : kwsc_build_seq
`default_nettype wire

>>> hw/rtl/kwsc_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Substitution table
// Holds the 26 cipher letters and maps one byte through them.
// ----------------------------------------------------------------------------
module kwsc_table (
   input  wire                                  clock,
   input  wire kwsc_pkg::tbl_wr_type            tbl_wr,
   input  wire [kwsc_pkg::CharWidth-1:0]        plain_char,
   output logic [kwsc_pkg::CharWidth-1:0]       cipher_char
);
   import kwsc_pkg::*;

   letter_type entry_ff [AlphaSize];

   logic       is_lower;
   letter_type rd_idx;
   letter_type rd_letter;

   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         entry_ff[tbl_wr.pos] <= tbl_wr.letter;
      end
   end

   assign is_lower    = (plain_char >= CharWidth'(LowerA))
                        && (plain_char <= CharWidth'(LowerZ));
   assign rd_idx      = is_lower ? LetterWidth'(plain_char - CharWidth'(LowerA)) : '0;
   assign rd_letter   = entry_ff[rd_idx];
   assign cipher_char = is_lower ? (CharWidth'(LowerA) + CharWidth'(rd_letter))
                                 : plain_char;

endmodule : kwsc_table
`default_nettype wire

>>> test/keyword_substitution_cipher_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Keyword substitution cipher unit testbench
// Programs keywords through the configuration channel, streams plaintext
// bytes and checks every ciphertext byte against an in-bench substitution
// alphabet, with random gaps on the plaintext side and random back-pressure
// on the ciphertext side.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher_unit_tb;
   import kwsc_pkg::*;

   // Indexes above the register map; writes there must be dropped.
   localparam logic [CsrIdxWidth-1:0] CsrFirstUnmapped = CsrKeyLettersD + 3'd1;
   localparam int CsrLastIndex     = (1 << CsrIdxWidth) - 1;
   localparam int RandomPhases     = 8;
   localparam int CharsPerPhase    = 140;
   localparam int ReportLimit      = 10;
   localparam int DrainCycles      = 12;
   localparam int RunLimit         = 4_000_000;

   typedef struct {
      logic [CharWidth-1:0] plain;
      logic [CharWidth-1:0] cipher;
   } cipher_pair_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the key registers, derives the substitution alphabet
   // and holds the ciphertext bytes still owed by the unit, oldest first.
   // -------------------------------------------------------------------------
   class cipher_scoreboard;
      logic [KeyLenWidth-1:0] key_len;
      key_word_type           key_bank [KeyRegs];
      letter_type             alphabet [AlphaSize];
      bit                     alphabet_built;
      cipher_pair_type        cipher_due [$];
      int                     failures;

      function new();
         key_len = '0;
         foreach (key_bank[r]) key_bank[r] = '0;
         alphabet_built = 1'b0;
         failures = 0;
      endfunction

      function void complain(string msg);
         failures++;
         if (failures <= ReportLimit) $display("%s", msg);
      endfunction

      // Mirror one configuration write; unmapped indexes leave everything alone.
      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [KeyRegWidth-1:0] data);
         if (idx == CsrKeyLength) begin
            key_len = data[KeyLenWidth-1:0];
         end else if (idx <= CsrKeyLettersD) begin
            key_bank[idx - CsrKeyLettersA] = data;
         end else begin
            return;
         end
         alphabet_built = 1'b0;
      endfunction

      // Distinct keyword letters first, in order of appearance, then the
      // unused letters from z down to a.
      function void build_alphabet();
         logic [AlphaSize-1:0] taken;
         int                   n;
         int                   slot;
         letter_type           code;
         taken = '0;
         slot  = 0;
         n     = (key_len > MaxKeyLetters) ? MaxKeyLetters : key_len;
         for (int i = 0; i < n; i++) begin
            code = key_bank[i / LettersPerReg][i % LettersPerReg];
            if (code < AlphaSize && !taken[code]) begin
               alphabet[slot] = code;
               taken[code]    = 1'b1;
               slot++;
            end
         end
         for (int c = AlphaSize - 1; c >= 0; c--) begin
            if (!taken[c]) begin
               alphabet[slot] = letter_type'(c);
               slot++;
            end
         end
         alphabet_built = 1'b1;
      endfunction

      function logic [CharWidth-1:0] encipher_byte(logic [CharWidth-1:0] c);
         if (c >= LowerA && c <= LowerZ) return CharWidth'(LowerA + alphabet[c - LowerA]);
         return c;
      endfunction

      // Note an accepted plaintext transaction.
      function void note_plain(logic [CharWidth-1:0] c);
         cipher_pair_type p;
         if (!alphabet_built) build_alphabet();
         p.plain  = c;
         p.cipher = encipher_byte(c);
         cipher_due.push_back(p);
      endfunction

      // Check an accepted ciphertext transaction against the oldest expectation.
      function void check_cipher(logic [CharWidth-1:0] got);
         cipher_pair_type p;
         if (cipher_due.size() == 0) begin
            complain($sformatf("unexpected ciphertext byte %h", got));
            return;
         end
         p = cipher_due.pop_front();
         if (got !== p.cipher)
            complain($sformatf("cipher mismatch: plain %h expected %h got %h",
                               p.plain, p.cipher, got));
      endfunction

      function int pending();
         return cipher_due.size();
      endfunction

      function void close_out();
         foreach (cipher_due[i])
            complain($sformatf("missing ciphertext for plain %h (expected %h)",
                               cipher_due[i].plain, cipher_due[i].cipher));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;

   kwsc_req_if req_if ();
   kwsc_rsp_if rsp_if ();
   kwsc_csr_if csr_if ();

   cipher_scoreboard sb = new();

   keyword_substitution_cipher_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample the ciphertext handshake with pre-edge values, then pick the
   // ready level for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) sb.check_cipher(rsp_if.cipher_char);
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function bit sender_idles();
      return $urandom_range(99) < sender_idle_pct;
   endfunction

   // Offer one plaintext byte and hold it until the unit takes it. Valid is
   // lowered only for an idle stretch, so back-to-back transactions keep it high.
   task automatic send_plain(input logic [CharWidth-1:0] c);
      if (sender_idles()) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while (sender_idles());
      end
      req_if.valid      <= 1'b1;
      req_if.plain_char <= c;
      do @(posedge clock); while (!req_if.ready);
      sb.note_plain(c);
   endtask

   task automatic end_burst();
      req_if.valid <= 1'b0;
   endtask

   // One configuration transaction; valid stays high for a following write.
   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [KeyRegWidth-1:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wr_data   <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
   endtask

   task automatic end_csr();
      csr_if.valid <= 1'b0;
   endtask

   // Hold off until every ciphertext byte owed has been handed over.
   task automatic wait_for_cipher();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic key_word_type random_letters(input int max_code);
      key_word_type w;
      for (int k = 0; k < LettersPerReg; k++) w[k] = letter_type'($urandom_range(max_code));
      return w;
   endfunction

   function automatic logic [KeyRegWidth-1:0] random_raw_word();
      return KeyRegWidth'({$urandom, $urandom});
   endfunction

   function automatic logic [CharWidth-1:0] random_plain();
      if ($urandom_range(99) < 70) return CharWidth'(LowerA + $urandom_range(AlphaSize - 1));
      return CharWidth'($urandom_range(255));
   endfunction

   function automatic logic [CsrIdxWidth-1:0] random_unmapped();
      return CsrIdxWidth'($urandom_range(CsrLastIndex, CsrFirstUnmapped));
   endfunction

   // Program one keyword setting for a random phase; the unit must be idle.
   task automatic apply_setting(input int kind);
      case (kind)
         0: begin
            // empty keyword over all-zero letters
            write_csr(CsrKeyLength, '0);
            write_csr(CsrKeyLettersA, '0);
            write_csr(CsrKeyLettersB, '0);
            write_csr(CsrKeyLettersC, '0);
            write_csr(CsrKeyLettersD, '0);
         end
         1: begin
            // full length, every code a non-letter: reversed alphabet again
            write_csr(CsrKeyLength, KeyRegWidth'(MaxKeyLetters));
            write_csr(CsrKeyLettersA, '1);
            write_csr(CsrKeyLettersB, '1);
            write_csr(CsrKeyLettersC, '1);
            write_csr(CsrKeyLettersD, '1);
            write_csr(random_unmapped(), random_raw_word());
         end
         2: begin
            // length beyond the cap, letters only
            write_csr(CsrKeyLength, KeyRegWidth'((1 << KeyLenWidth) - 1));
            write_csr(CsrKeyLettersA, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersB, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersC, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersD, random_letters(AlphaSize - 1));
         end
         3: begin
            write_csr(CsrKeyLettersD, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersC, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersB, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersA, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLength, KeyRegWidth'(AlphaSize));
         end
         4: begin
            write_csr(CsrKeyLength, KeyRegWidth'($urandom_range(LettersPerReg, 1)));
            write_csr(CsrKeyLettersA, random_raw_word());
         end
         5: begin
            // a repeated 'a' across the whole keyword
            write_csr(CsrKeyLettersA, '0);
            write_csr(CsrKeyLettersB, '0);
            write_csr(CsrKeyLettersC, '0);
            write_csr(CsrKeyLettersD, '0);
            write_csr(CsrKeyLength, KeyRegWidth'(MaxKeyLetters));
         end
         6: begin
            write_csr(CsrKeyLength, KeyRegWidth'($urandom_range((1 << KeyLenWidth) - 1)));
            write_csr(CsrKeyLettersA, random_raw_word());
            write_csr(CsrKeyLettersB, random_raw_word());
            write_csr(random_unmapped(), random_raw_word());
            write_csr(CsrKeyLettersC, random_raw_word());
            write_csr(CsrKeyLettersD, random_raw_word());
         end
         default: begin
            write_csr(CsrKeyLength, KeyRegWidth'($urandom_range(MaxKeyLetters, 1)));
            write_csr(CsrKeyLettersA, random_raw_word());
            write_csr(CsrKeyLettersB, random_letters(AlphaSize - 1));
            write_csr(CsrKeyLettersC, random_raw_word());
            write_csr(CsrKeyLettersD, random_letters(AlphaSize - 1));
         end
      endcase
      end_csr();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      key_word_type kw;
      logic [CharWidth-1:0] edge_chars [8];

      req_if.valid       = 1'b0;
      req_if.plain_char  = '0;
      rsp_if.ready       = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.reg_index   = CsrKeyLength;
      csr_if.wr_data     = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      reset              = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: the table after reset is the reversed alphabet. Cover the
      // letter bounds, their neighbours and the all-zero and all-one bytes.
      edge_chars = '{8'h00, 8'hff, 8'(LowerA - 1), 8'(LowerA), 8'(LowerZ),
                     8'(LowerZ + 1), 8'h41, 8'h6d};
      foreach (edge_chars[i]) send_plain(edge_chars[i]);
      end_burst();
      wait_for_cipher();

      // Directed: "keyword" with a non-letter code and repeated letters,
      // followed by a write to an unmapped index that must be dropped.
      kw     = '1;
      kw[0]  = 5'd10;
      kw[1]  = 5'd4;
      kw[2]  = 5'd24;
      kw[3]  = 5'd22;
      kw[4]  = 5'd14;
      kw[5]  = 5'd27;
      kw[6]  = 5'd17;
      kw[7]  = 5'd3;
      kw[8]  = 5'd4;
      kw[9]  = 5'd10;
      write_csr(CsrKeyLettersA, kw);
      write_csr(CsrKeyLength, KeyRegWidth'(10));
      write_csr(CsrFirstUnmapped, '0);
      end_csr();
      receiver_stall_pct = 30;
      send_plain(8'(LowerA));
      send_plain(8'(LowerA + 5));
      send_plain(8'(LowerA + 6));
      send_plain(8'(LowerZ));
      send_plain(8'h20);
      end_burst();
      wait_for_cipher();

      // Directed: length above the cap, letters spread over all four words.
      write_csr(CsrKeyLettersB, random_letters(AlphaSize - 1));
      write_csr(CsrKeyLettersC, random_letters(AlphaSize - 1));
      write_csr(CsrKeyLettersD, random_letters(AlphaSize - 1));
      write_csr(CsrKeyLength, KeyRegWidth'((1 << KeyLenWidth) - 1));
      end_csr();
      send_plain(8'(LowerA));
      send_plain(8'(LowerA + 13));
      send_plain(8'(LowerZ));
      send_plain(8'h7f);
      end_burst();
      wait_for_cipher();

      // Random phases: a fresh keyword each time, cycling through the idling
      // mixes so gaps and stalls land on table builds and on streaming.
      for (int ph = 0; ph < RandomPhases; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         apply_setting(ph);
         for (int k = 0; k < CharsPerPhase; k++) send_plain(random_plain());
         end_burst();
         wait_for_cipher();
      end

      // Let any stray ciphertext show up before the verdict.
      receiver_stall_pct = 0;
      repeat (DrainCycles) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0) begin
         $display("keyword_substitution_cipher_unit_tb OK");
      end else begin
         $display("keyword_substitution_cipher_unit_tb NOT OK");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      #RunLimit;
      $display("keyword_substitution_cipher_unit_tb NOT OK");
      $finish;
   end

endmodule : keyword_substitution_cipher_unit_tb
`default_nettype wire
